### rtl/hsv2rgb_pkg.sv
// Types, constants and helper functions for the HSV to RGB converter.
package hsv2rgb_pkg;

	typedef enum logic [2:0] {
		SECTOR_RED_YELLOW    = 3'd0,
		SECTOR_YELLOW_GREEN  = 3'd1,
		SECTOR_GREEN_CYAN    = 3'd2,
		SECTOR_CYAN_BLUE     = 3'd3,
		SECTOR_BLUE_MAGENTA  = 3'd4,
		SECTOR_MAGENTA_RED   = 3'd5
	} sector_t;

	localparam logic [18:0] HUE_SECTORS   = 19'd6;
	localparam logic [7:0]  CHANNEL_FULL  = 8'd255;
	localparam logic [16:0] HUE_ONE       = 17'd65536;
	localparam logic [24:0] TERM_ONE      = 25'd16711680;
	localparam logic [31:0] DIV255_MAGIC  = 32'h0000_8081;

	// Exact floor(x / 255) for any 16-bit x up to 65279, whose quotient fits the 8-bit result.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [31:0] prod;
		prod = {16'b0, x} * DIV255_MAGIC;
		return prod[30:23];
	endfunction

endpackage

### rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter: five-stage pipeline, one pixel per clock cycle while the output is not stalled.
// An accepted input transaction passes through registers s1 to s5 in order to its output transaction.
// Throughput is one transaction per cycle while rgb_stall is low; a stage advances whenever the stage after it is free.
// The multiplier chain (hue times six, fraction times saturation, value times term, divide by 255) sets the depth.
// Reset clears all valid bits asynchronously; data registers are not reset.
module hsv_to_rgb_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [15:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        rgb_valid,
	input  logic        rgb_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	logic [18:0] h6_s1;
	logic [7:0]  sat_s1, val_s1;

	hsv2rgb_pkg::sector_t sector_s2, sector_s3, sector_s4;
	logic [23:0] fsq_s2;
	logic [24:0] fst_s2;
	logic [15:0] pprod_s2;
	logic [7:0]  val_s2, val_s3, val_s4;

	logic [15:0] xq_s3, xt_s3, xp_s3;
	logic [7:0]  p_s4, q_s4, t_s4;

	logic [7:0]  red_s5, green_s5, blue_s5;

	logic [24:0] dq, dt;
	logic [31:0] nq, nt;
	logic [16:0] frac_t;

	assign adv_s5    = !valid_s5 || !rgb_stall;
	assign adv_s4    = !valid_s4 || adv_s5;
	assign adv_s3    = !valid_s3 || adv_s4;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign pix_stall = !adv_s1;

	assign frac_t = hsv2rgb_pkg::HUE_ONE - {1'b0, h6_s1[15:0]};
	assign dq     = hsv2rgb_pkg::TERM_ONE - {1'b0, fsq_s2};
	assign dt     = hsv2rgb_pkg::TERM_ONE - fst_s2;
	assign nq     = {24'b0, val_s2} * {8'b0, dq[23:0]};
	assign nt     = {24'b0, val_s2} * {8'b0, dt[23:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= pix_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_valid) begin
			h6_s1  <= {3'b0, hue} * hsv2rgb_pkg::HUE_SECTORS;
			sat_s1 <= saturation;
			val_s1 <= brightness;
		end
		if (adv_s2 && valid_s1) begin
			sector_s2 <= hsv2rgb_pkg::sector_t'(h6_s1[18:16]);
			fsq_s2    <= {8'b0, h6_s1[15:0]} * {16'b0, sat_s1};
			fst_s2    <= {8'b0, frac_t} * {17'b0, sat_s1};
			pprod_s2  <= {8'b0, val_s1} * {8'b0, hsv2rgb_pkg::CHANNEL_FULL - sat_s1};
			val_s2    <= val_s1;
		end
		if (adv_s3 && valid_s2) begin
			sector_s3 <= sector_s2;
			xq_s3     <= nq[31:16];
			xt_s3     <= nt[31:16];
			xp_s3     <= pprod_s2;
			val_s3    <= val_s2;
		end
		if (adv_s4 && valid_s3) begin
			sector_s4 <= sector_s3;
			q_s4      <= hsv2rgb_pkg::div255(xq_s3);
			t_s4      <= hsv2rgb_pkg::div255(xt_s3);
			p_s4      <= hsv2rgb_pkg::div255(xp_s3);
			val_s4    <= val_s3;
		end
		if (adv_s5 && valid_s4) begin
			case (sector_s4)
				hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
					red_s5 <= val_s4; green_s5 <= t_s4; blue_s5 <= p_s4;
				end
				hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
					red_s5 <= q_s4; green_s5 <= val_s4; blue_s5 <= p_s4;
				end
				hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
					red_s5 <= p_s4; green_s5 <= val_s4; blue_s5 <= t_s4;
				end
				hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
					red_s5 <= p_s4; green_s5 <= q_s4; blue_s5 <= val_s4;
				end
				hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
					red_s5 <= t_s4; green_s5 <= p_s4; blue_s5 <= val_s4;
				end
				default: begin
					red_s5 <= val_s4; green_s5 <= p_s4; blue_s5 <= q_s4;
				end
			endcase
		end
	end

	assign rgb_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

endmodule

### tb/hsv_rgb_checker.sv
// Checker for the HSV to RGB converter: predicts each pixel's color and compares the outputs.
module hsv_rgb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	input  logic        pix_stall,
	input  logic [15:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	input  logic        rgb_valid,
	input  logic        rgb_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output int          mismatches,
	output int          pending,
	output int          rgb_checked
);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_pixel_t;

	rgb_pixel_t rgb_expected[$];

	function automatic rgb_pixel_t hsv_pixel_to_rgb(input logic [15:0] h, input logic [7:0] s,
			input logic [7:0] v);
		logic [63:0] h6;
		logic [63:0] frac;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] t;
		logic [63:0] full;
		logic [63:0] term_one;
		rgb_pixel_t px;
		full = 64'(hsv2rgb_pkg::CHANNEL_FULL);
		term_one = 64'(hsv2rgb_pkg::TERM_ONE);
		h6 = 64'(h) * 64'(hsv2rgb_pkg::HUE_SECTORS);
		frac = {48'b0, h6[15:0]};
		p = (64'(v) * (full - 64'(s))) / full;
		q = (64'(v) * (term_one - frac * 64'(s))) / term_one;
		t = (64'(v) * (term_one - (64'(hsv2rgb_pkg::HUE_ONE) - frac) * 64'(s))) / term_one;
		case (hsv2rgb_pkg::sector_t'(h6[18:16]))
			hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
				px = '{v, t[7:0], p[7:0]};
			end
			hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
				px = '{q[7:0], v, p[7:0]};
			end
			hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
				px = '{p[7:0], v, t[7:0]};
			end
			hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
				px = '{p[7:0], q[7:0], v};
			end
			hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
				px = '{t[7:0], p[7:0], v};
			end
			default: begin
				px = '{v, p[7:0], q[7:0]};
			end
		endcase
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_pixel_t want;
		if (!arst_n) begin
			rgb_expected.delete();
			pending <= 0;
			mismatches <= 0;
			rgb_checked <= 0;
		end else begin
			if (pix_valid && !pix_stall)
				rgb_expected.push_back(hsv_pixel_to_rgb(hue, saturation, brightness));
			if (rgb_valid && !rgb_stall) begin
				if (rgb_expected.size() == 0) begin
					if (mismatches < 10)
						$display("Unexpected transaction: rgb %0d/%0d/%0d", red, green, blue);
					mismatches <= mismatches + 1;
				end else begin
					want = rgb_expected.pop_front();
					rgb_checked <= rgb_checked + 1;
					if (want.r !== red || want.g !== green || want.b !== blue) begin
						if (mismatches < 10)
							$display("Mismatch on result %0d: expected rgb %0d/%0d/%0d, got %0d/%0d/%0d",
								rgb_checked, want.r, want.g, want.b, red, green, blue);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= rgb_expected.size();
		end
	end

endmodule

### tb/tb_top.sv
// Top of the HSV to RGB converter testbench: clock, reset, stimulus and verdict.
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_stall;
	logic [15:0] hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;
	logic        rgb_valid;
	logic        rgb_stall;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	int          mismatches;
	int          pending;
	int          rgb_checked;
	int          pixels_sent;
	bit          idle_on;
	bit          long_hold;
	int          hold_left;
	int          drain;

	hsv_to_rgb_converter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	hsv_rgb_checker checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.mismatches (mismatches),
		.pending    (pending),
		.rgb_checked(rgb_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Timeout with %0d results outstanding.", pending);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		rgb_stall <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				rgb_stall <= 1'b1;
				hold_left--;
			end else begin
				rgb_stall <= idle_on && ($urandom_range(0, 99) < 9);
			end
		end
	end

	task automatic send_pixel(input logic [15:0] h, input logic [7:0] s, input logic [7:0] v);
		if (idle_on && $urandom_range(0, 99) < 9) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		int unsigned mode;
		int unsigned k;
		logic [15:0] h;
		logic [7:0]  s;
		logic [7:0]  v;
		mode = $urandom_range(0, 9);
		h = 16'($urandom);
		s = 8'($urandom);
		v = 8'($urandom);
		case (mode)
			6: begin
				s = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			7: begin
				v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			8: begin
				k = $urandom_range(0, 5);
				h = 16'((k * 65536 + 5) / 6 + $urandom_range(0, 6) - 3);
			end
			9: begin
				h = 16'(65535 - $urandom_range(0, 15));
			end
			default: begin
			end
		endcase
		send_pixel(h, s, v);
	endtask

	initial begin
		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		hue <= '0;
		saturation <= '0;
		brightness <= '0;
		pixels_sent = 0;
		idle_on = 1'b1;
		long_hold = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(16'd0, 8'd255, 8'd255);
		send_pixel(16'd65535, 8'd255, 8'd255);
		send_pixel(16'd65535, 8'd0, 8'd200);
		send_pixel(16'd10922, 8'd255, 8'd255);
		send_pixel(16'd10923, 8'd255, 8'd255);
		send_pixel(16'd21845, 8'd200, 8'd255);
		send_pixel(16'd21846, 8'd200, 8'd255);
		send_pixel(16'd32767, 8'd128, 8'd240);
		send_pixel(16'd32768, 8'd128, 8'd240);
		send_pixel(16'd43690, 8'd255, 8'd100);
		send_pixel(16'd43691, 8'd255, 8'd100);
		send_pixel(16'd54613, 8'd255, 8'd255);
		send_pixel(16'd54614, 8'd1, 8'd255);
		send_pixel(16'd12345, 8'd0, 8'd0);
		send_pixel(16'd12345, 8'd0, 8'd255);
		send_pixel(16'd40000, 8'd0, 8'd77);
		send_pixel(16'd5000, 8'd255, 8'd0);
		send_pixel(16'd60000, 8'd254, 8'd1);
		send_pixel(16'hAAAA, 8'h55, 8'hAA);
		send_pixel(16'h5555, 8'hAA, 8'h55);

		for (int i = 0; i < 1030; i++) begin
			if (i == 200)
				long_hold = 1'b1;
			if (i == 500) begin
				pix_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			idle_on = !(i >= 650 && i < 900);
			send_random_pixel();
		end

		pix_valid <= 1'b0;
		@(posedge clk);
		drain = 0;
		while (pending != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (12) @(posedge clk);

		$display("Summary: %0d pixels sent, %0d conversions checked, %0d mismatches.",
			pixels_sent, rgb_checked, mismatches);
		$display("Covered all six hue sectors and their edges, grey and saturated pixels,");
		$display("a long output hold-off, a drain pause and a stretch at full rate.");
		if (mismatches == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
